/* sv/direction_to_quaternion_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the direction-to-quaternion block
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DIRECTION_TO_QUATERNION_ASSERT_SVH
`define DIRECTION_TO_QUATERNION_ASSERT_SVH

// property that must hold at every clock edge
`define DTQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("dtq: assertion failed");

// condition in one cycle implies a condition in the next
`define DTQ_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("dtq: assertion failed");

`endif

/* sv/dtq_pkg.sv */
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared widths, constants and status codes for the direction-to-quaternion
// pipeline.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int COORD_W   = 32;            // coordinate width, Q16.16
  localparam int D_W       = COORD_W + 1;   // difference width
  localparam int SH_W      = $clog2(D_W);   // normalising shift amount
  localparam int NORM_MSB  = 29;            // scaled magnitudes in [2^29, 2^30)

  // pipelined square root: radicand 64 bits, root 32 bits, one bit a stage
  localparam int SQ_OUT_W  = 32;
  localparam int SQ_IN_W   = 2 * SQ_OUT_W;
  localparam int SQ_REM_W  = SQ_OUT_W + 3;

  // pipelined divider: 62-bit numerator, 32-bit divisor, 32 quotient bits
  localparam int DV_NUM_W  = 62;
  localparam int DV_DEN_W  = 32;
  localparam int DV_Q_W    = 32;

  // sideband carried through the long units
  localparam int SIDE_W    = 104;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_VERT  = 2'd2;
  localparam logic [1:0] ST_TRACE = 2'd3;

endpackage

/* sv/dtq_sqrt_pipe.sv */
// ----------------------------------------------------------------------------
// dtq_sqrt_pipe
// Floor square root, one root bit per register stage, sideband alongside.
// ----------------------------------------------------------------------------
module dtq_sqrt_pipe (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [dtq_pkg::SIDE_W-1:0]   in_side,
  input  logic [dtq_pkg::SQ_IN_W-1:0]  in_rad,
  output logic                         out_vld,
  output logic [dtq_pkg::SIDE_W-1:0]   out_side,
  output logic [dtq_pkg::SQ_OUT_W-1:0] out_root
);

  logic [dtq_pkg::SQ_REM_W-1:0] rem_r  [dtq_pkg::SQ_OUT_W];
  logic [dtq_pkg::SQ_OUT_W-1:0] root_r [dtq_pkg::SQ_OUT_W];
  logic [dtq_pkg::SQ_IN_W-1:0]  rad_r  [dtq_pkg::SQ_OUT_W];
  logic [dtq_pkg::SIDE_W-1:0]   side_r [dtq_pkg::SQ_OUT_W];
  logic                         vld_r  [dtq_pkg::SQ_OUT_W];

  for (genvar k = 0; k < dtq_pkg::SQ_OUT_W; k++) begin : g_st
    logic [dtq_pkg::SQ_REM_W-1:0] rem_in;
    logic [dtq_pkg::SQ_OUT_W-1:0] root_in;
    logic [dtq_pkg::SQ_IN_W-1:0]  rad_in;
    logic [dtq_pkg::SIDE_W-1:0]   side_in;
    logic                         vld_in;
    logic [dtq_pkg::SQ_REM_W-1:0] rem_sh;
    logic [dtq_pkg::SQ_REM_W-1:0] trial;
    logic                         ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign side_in = in_side;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign side_in = side_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    assign rem_sh = {rem_in[dtq_pkg::SQ_REM_W-3:0],
                     rad_in[dtq_pkg::SQ_IN_W-1 -: 2]};
    assign trial  = dtq_pkg::SQ_REM_W'({root_in, 2'b01});
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? rem_sh - trial : rem_sh;
        root_r[k] <= {root_in[dtq_pkg::SQ_OUT_W-2:0], ge};
        rad_r[k]  <= {rad_in[dtq_pkg::SQ_IN_W-3:0], 2'b00};
        side_r[k] <= side_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end
  end

  assign out_vld  = vld_r[dtq_pkg::SQ_OUT_W-1];
  assign out_side = side_r[dtq_pkg::SQ_OUT_W-1];
  assign out_root = root_r[dtq_pkg::SQ_OUT_W-1];

endmodule

/* sv/dtq_div_pipe.sv */
// ----------------------------------------------------------------------------
// dtq_div_pipe
// Restoring unsigned divider, one quotient bit per register stage. Flags a
// quotient that does not fit the quotient width.
// ----------------------------------------------------------------------------
module dtq_div_pipe (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic [dtq_pkg::SIDE_W-1:0]    in_side,
  input  logic [dtq_pkg::DV_NUM_W-1:0]  in_num,
  input  logic [dtq_pkg::DV_DEN_W-1:0]  in_den,
  output logic                          out_vld,
  output logic [dtq_pkg::SIDE_W-1:0]    out_side,
  output logic [dtq_pkg::DV_Q_W-1:0]    out_quo,
  output logic                          out_ovf
);

  logic [dtq_pkg::DV_DEN_W-1:0] rem_r  [dtq_pkg::DV_Q_W];
  logic [dtq_pkg::DV_Q_W-1:0]   quo_r  [dtq_pkg::DV_Q_W];
  logic [dtq_pkg::DV_Q_W-1:0]   nb_r   [dtq_pkg::DV_Q_W];
  logic [dtq_pkg::DV_DEN_W-1:0] den_r  [dtq_pkg::DV_Q_W];
  logic                         ovf_r  [dtq_pkg::DV_Q_W];
  logic [dtq_pkg::SIDE_W-1:0]   side_r [dtq_pkg::DV_Q_W];
  logic                         vld_r  [dtq_pkg::DV_Q_W];

  for (genvar k = 0; k < dtq_pkg::DV_Q_W; k++) begin : g_st
    logic [dtq_pkg::DV_DEN_W-1:0] rem_in;
    logic [dtq_pkg::DV_Q_W-1:0]   quo_in;
    logic [dtq_pkg::DV_Q_W-1:0]   nb_in;
    logic [dtq_pkg::DV_DEN_W-1:0] den_in;
    logic                         ovf_in;
    logic [dtq_pkg::SIDE_W-1:0]   side_in;
    logic                         vld_in;
    logic [dtq_pkg::DV_DEN_W:0]   rem_sh;
    logic [dtq_pkg::DV_DEN_W:0]   diff;
    logic                         ge;

    if (k == 0) begin : g_first
      assign rem_in  = dtq_pkg::DV_DEN_W'(in_num[dtq_pkg::DV_NUM_W-1:dtq_pkg::DV_Q_W]);
      assign quo_in  = '0;
      assign nb_in   = in_num[dtq_pkg::DV_Q_W-1:0];
      assign den_in  = in_den;
      assign ovf_in  = dtq_pkg::DV_DEN_W'(in_num[dtq_pkg::DV_NUM_W-1:dtq_pkg::DV_Q_W])
                       >= in_den;
      assign side_in = in_side;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign nb_in   = nb_r[k-1];
      assign den_in  = den_r[k-1];
      assign ovf_in  = ovf_r[k-1];
      assign side_in = side_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    assign rem_sh = {rem_in, nb_in[dtq_pkg::DV_Q_W-1]};
    assign ge     = rem_sh >= {1'b0, den_in};
    assign diff   = rem_sh - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[dtq_pkg::DV_DEN_W-1:0] : rem_sh[dtq_pkg::DV_DEN_W-1:0];
        quo_r[k]  <= {quo_in[dtq_pkg::DV_Q_W-2:0], ge};
        nb_r[k]   <= {nb_in[dtq_pkg::DV_Q_W-2:0], 1'b0};
        den_r[k]  <= den_in;
        ovf_r[k]  <= ovf_in;
        side_r[k] <= side_in;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end
  end

  assign out_vld  = vld_r[dtq_pkg::DV_Q_W-1];
  assign out_side = side_r[dtq_pkg::DV_Q_W-1];
  assign out_quo  = quo_r[dtq_pkg::DV_Q_W-1];
  assign out_ovf  = ovf_r[dtq_pkg::DV_Q_W-1];

endmodule

/* sv/direction_to_quaternion.sv */
// Throughput: one transaction per cycle; the whole pipe advances together
// and freezes only while a result sits in the output register unclaimed.
// Depth is set by two square-root rows and two divider rows, one bit a stage.
// Reset (rst_n low, synchronous) clears every stage valid; data is not reset.
// ----------------------------------------------------------------------------
// direction_to_quaternion
// Look rotation: unit direction between two points, orthonormal basis, then
// trace-form conversion to a Q2.30 unit quaternion with status.
// ----------------------------------------------------------------------------
`include "direction_to_quaternion_assert.svh"

module direction_to_quaternion (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // from_x[31:0], from_y[63:32], from_z[95:64], to_x[127:96], to_y[159:128],
  // to_z[191:160]
  input  logic [191:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // quat_w[31:0], quat_x[63:32], quat_y[95:64], quat_z[127:96]
  output logic [127:0] out_tdata,
  // status[1:0]
  output logic [1:0]   out_tuser
);

  // sideband payloads through the long units
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  neg;
    logic [29:0] ms2;
    logic [29:0] ms1;
    logic [29:0] ms0;
  } sq1_side_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] sgn;     // fx fy fz rx rz, lowest bit fx
  } dv1_side_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  asg;
    logic [31:0] amz;
    logic [31:0] amy;
    logic [31:0] amx;
  } sq2_side_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  asg;
    logic [30:0] w;
  } dv2_side_t;

  // round half away from zero of v / 2^30
  function automatic logic signed [34:0] rnd30(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [63:0] q;
    mag = v[63] ? 64'(-v) : 64'(v);
    q   = (mag + 64'd536870912) >> 30;
    rnd30 = v[63] ? -$signed(q[34:0]) : $signed(q[34:0]);
  endfunction

  // global advance: the pipe moves unless the output holds an unclaimed result
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------- S0: differences ----------------
  logic                          v0_r;
  logic signed [dtq_pkg::D_W-1:0] d_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i] <= dtq_pkg::D_W'($signed(in_tdata[(i+3)*32 +: dtq_pkg::COORD_W]))
                - dtq_pkg::D_W'($signed(in_tdata[i*32 +: dtq_pkg::COORD_W]));
      end
    end
  end

  // ---------------- S1: magnitudes and largest ----------------
  logic                     v1_r;
  logic [dtq_pkg::D_W-1:0]  m1_r [3];
  logic [2:0]               neg1_r;
  logic [dtq_pkg::D_W-1:0]  mx1_r;
  logic [dtq_pkg::D_W-1:0]  m1_nxt [3];
  logic [dtq_pkg::D_W-1:0]  mx1_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m1_nxt[i] = d_r[i][dtq_pkg::D_W-1] ? dtq_pkg::D_W'(-d_r[i]) : dtq_pkg::D_W'(d_r[i]);
    end
    mx1_nxt = m1_nxt[0];
    if (m1_nxt[1] > mx1_nxt) mx1_nxt = m1_nxt[1];
    if (m1_nxt[2] > mx1_nxt) mx1_nxt = m1_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r   <= m1_nxt;
      mx1_r  <= mx1_nxt;
      neg1_r <= {d_r[2][dtq_pkg::D_W-1], d_r[1][dtq_pkg::D_W-1], d_r[0][dtq_pkg::D_W-1]};
    end
  end

  // ---------------- S2: leading one, shift amount ----------------
  logic                       v2_r;
  logic [dtq_pkg::D_W-1:0]    m2_r [3];
  logic [2:0]                 neg2_r;
  logic                       zero2_r;
  logic                       right2_r;
  logic [dtq_pkg::SH_W-1:0]   amt2_r;
  logic [dtq_pkg::SH_W-1:0]   pos;

  always_comb begin
    pos = '0;
    for (int b = 0; b < dtq_pkg::D_W; b++) begin
      if (mx1_r[b]) pos = dtq_pkg::SH_W'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_r     <= m1_r;
      neg2_r   <= neg1_r;
      zero2_r  <= mx1_r == '0;
      right2_r <= pos > dtq_pkg::SH_W'(dtq_pkg::NORM_MSB);
      amt2_r   <= (pos > dtq_pkg::SH_W'(dtq_pkg::NORM_MSB))
                  ? pos - dtq_pkg::SH_W'(dtq_pkg::NORM_MSB)
                  : dtq_pkg::SH_W'(dtq_pkg::NORM_MSB) - pos;
    end
  end

  // ---------------- S3: scale, early status ----------------
  logic        v3_r;
  logic [29:0] ms3_r [3];
  logic [2:0]  neg3_r;
  logic [1:0]  st3_r;
  logic [29:0] ms3_nxt [3];
  logic [dtq_pkg::D_W-1:0] shv [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shv[i]     = right2_r ? (m2_r[i] >> amt2_r) : (m2_r[i] << amt2_r);
      ms3_nxt[i] = shv[i][29:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ms3_r  <= ms3_nxt;
      neg3_r <= neg2_r;
      if (zero2_r) begin
        st3_r <= dtq_pkg::ST_ZERO;
      end else if (ms3_nxt[0] == '0 && ms3_nxt[2] == '0) begin
        st3_r <= dtq_pkg::ST_VERT;
      end else begin
        st3_r <= dtq_pkg::ST_OK;
      end
    end
  end

  // ---------------- S4: squares ----------------
  logic        v4_r;
  logic [59:0] sq4_r [3];
  logic [29:0] ms4_r [3];
  logic [2:0]  neg4_r;
  logic [1:0]  st4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq4_r[i] <= 60'(ms3_r[i]) * 60'(ms3_r[i]);
      end
      ms4_r  <= ms3_r;
      neg4_r <= neg3_r;
      st4_r  <= st3_r;
    end
  end

  // ---------------- S5: sums of squares ----------------
  logic                         v5_r;
  logic [dtq_pkg::SQ_IN_W-1:0]  sum_l5_r;
  logic [dtq_pkg::SQ_IN_W-1:0]  sum_h5_r;
  sq1_side_t                    sd5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_l5_r     <= dtq_pkg::SQ_IN_W'(sq4_r[0]) + dtq_pkg::SQ_IN_W'(sq4_r[1])
                    + dtq_pkg::SQ_IN_W'(sq4_r[2]);
      sum_h5_r     <= dtq_pkg::SQ_IN_W'(sq4_r[0]) + dtq_pkg::SQ_IN_W'(sq4_r[2]);
      sd5_r.status <= st4_r;
      sd5_r.neg    <= neg4_r;
      sd5_r.ms0    <= ms4_r[0];
      sd5_r.ms1    <= ms4_r[1];
      sd5_r.ms2    <= ms4_r[2];
    end
  end

  // ---------------- lengths: full and horizontal ----------------
  logic                          sq1_vld;
  logic [dtq_pkg::SIDE_W-1:0]    sq1_side;
  logic [dtq_pkg::SQ_OUT_W-1:0]  len_l;
  logic [dtq_pkg::SQ_OUT_W-1:0]  len_h;
  sq1_side_t                     sd6;

  dtq_sqrt_pipe u_sqrt_len (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v5_r),
    .in_side  (dtq_pkg::SIDE_W'(sd5_r)),
    .in_rad   (sum_l5_r),
    .out_vld  (sq1_vld),
    .out_side (sq1_side),
    .out_root (len_l)
  );

  dtq_sqrt_pipe u_sqrt_hor (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v5_r),
    .in_side  ('0),
    .in_rad   (sum_h5_r),
    .out_vld  (),
    .out_side (),
    .out_root (len_h)
  );

  assign sd6 = sq1_side[$bits(sq1_side_t)-1:0];

  // ---------------- S6: rounding numerators ----------------
  logic                          v6_r;
  logic [dtq_pkg::DV_NUM_W-1:0]  num6_r [5];   // fx fy fz rx rz
  logic [dtq_pkg::DV_DEN_W-1:0]  lenl6_r;
  logic [dtq_pkg::DV_DEN_W-1:0]  lenh6_r;
  dv1_side_t                     sd6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      num6_r[0] <= dtq_pkg::DV_NUM_W'({sd6.ms0, 30'b0}) + dtq_pkg::DV_NUM_W'(len_l >> 1);
      num6_r[1] <= dtq_pkg::DV_NUM_W'({sd6.ms1, 30'b0}) + dtq_pkg::DV_NUM_W'(len_l >> 1);
      num6_r[2] <= dtq_pkg::DV_NUM_W'({sd6.ms2, 30'b0}) + dtq_pkg::DV_NUM_W'(len_l >> 1);
      num6_r[3] <= dtq_pkg::DV_NUM_W'({sd6.ms2, 30'b0}) + dtq_pkg::DV_NUM_W'(len_h >> 1);
      num6_r[4] <= dtq_pkg::DV_NUM_W'({sd6.ms0, 30'b0}) + dtq_pkg::DV_NUM_W'(len_h >> 1);
      lenl6_r   <= len_l;
      lenh6_r   <= len_h;
      sd6_r.status <= sd6.status;
      // right = (dz, 0, -dx)
      sd6_r.sgn    <= {!sd6.neg[0], sd6.neg[2], sd6.neg[2], sd6.neg[1], sd6.neg[0]};
    end
  end

  // ---------------- forward and right vectors ----------------
  logic                        dv1_vld;
  logic [dtq_pkg::SIDE_W-1:0]  dv1_side;
  logic [dtq_pkg::DV_Q_W-1:0]  quo1 [5];
  dv1_side_t                   sd7;

  for (genvar j = 0; j < 5; j++) begin : g_dv1
    if (j == 0) begin : g_main
      dtq_div_pipe u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v6_r),
        .in_side  (dtq_pkg::SIDE_W'(sd6_r)),
        .in_num   (num6_r[j]),
        .in_den   (lenl6_r),
        .out_vld  (dv1_vld),
        .out_side (dv1_side),
        .out_quo  (quo1[j]),
        .out_ovf  ()
      );
    end else begin : g_aux
      dtq_div_pipe u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v6_r),
        .in_side  ('0),
        .in_num   (num6_r[j]),
        .in_den   ((j < 3) ? lenl6_r : lenh6_r),
        .out_vld  (),
        .out_side (),
        .out_quo  (quo1[j]),
        .out_ovf  ()
      );
    end
  end

  assign sd7 = dv1_side[$bits(dv1_side_t)-1:0];

  // ---------------- S7: signed basis components ----------------
  logic               v7_r;
  logic signed [31:0] b7_r [5];   // fx fy fz rx rz
  logic [1:0]         st7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 5; i++) begin
        b7_r[i] <= sd7.sgn[i] ? -$signed(quo1[i]) : $signed(quo1[i]);
      end
      st7_r <= sd7.status;
    end
  end

  // ---------------- M1: up-vector products ----------------
  logic               vm1_r;
  logic signed [63:0] p_ux_r, p_a_r, p_b_r, p_uz_r;
  logic signed [31:0] bm1_r [5];
  logic [1:0]         stm1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_ux_r <= b7_r[1] * b7_r[4];   // fy*rz
      p_a_r  <= b7_r[2] * b7_r[3];   // fz*rx
      p_b_r  <= b7_r[0] * b7_r[4];   // fx*rz
      p_uz_r <= b7_r[1] * b7_r[3];   // fy*rx
      bm1_r  <= b7_r;
      stm1_r <= st7_r;
    end
  end

  // ---------------- M2: round up.x, up.z; form up.y difference ----------------
  logic               vm2_r;
  logic signed [34:0] ux2_r, uz2_r;
  logic signed [63:0] dif2_r;
  logic signed [31:0] bm2_r [5];
  logic [1:0]         stm2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ux2_r  <= rnd30(p_ux_r);
      uz2_r  <= -rnd30(p_uz_r);
      dif2_r <= p_a_r - p_b_r;
      bm2_r  <= bm1_r;
      stm2_r <= stm1_r;
    end
  end

  // ---------------- M3: round up.y ----------------
  logic               vm3_r;
  logic signed [34:0] ux3_r, uy3_r, uz3_r;
  logic signed [31:0] bm3_r [5];
  logic [1:0]         stm3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ux3_r  <= ux2_r;
      uy3_r  <= rnd30(dif2_r);
      uz3_r  <= uz2_r;
      bm3_r  <= bm2_r;
      stm3_r <= stm2_r;
    end
  end

  // ---------------- M4: trace and quaternion numerators ----------------
  logic                         vm4_r;
  logic [dtq_pkg::SQ_IN_W-1:0]  rad4_r;
  sq2_side_t                    sd4_r;
  logic signed [34:0]           tr;
  logic signed [34:0]           av [3];

  always_comb begin
    tr    = 35'(dtq_pkg::ONE_Q30) + 35'(bm3_r[3]) + uy3_r + 35'(bm3_r[2]);
    av[0] = uz3_r - 35'(bm3_r[1]);    // up.z - fy
    av[1] = 35'(bm3_r[0]) - 35'(bm3_r[4]);  // fx - rz
    av[2] = -ux3_r;                   // ry - up.x
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad4_r    <= (tr > 0) ? {tr[33:0], 30'b0} : '0;
      sd4_r.asg <= {av[2][34], av[1][34], av[0][34]};
      sd4_r.amx <= av[0][34] ? 32'(-av[0]) : 32'(av[0]);
      sd4_r.amy <= av[1][34] ? 32'(-av[1]) : 32'(av[1]);
      sd4_r.amz <= av[2][34] ? 32'(-av[2]) : 32'(av[2]);
      if (stm3_r == dtq_pkg::ST_OK && !(tr > 0)) begin
        sd4_r.status <= dtq_pkg::ST_TRACE;
      end else begin
        sd4_r.status <= stm3_r;
      end
    end
  end

  // ---------------- s = sqrt(t) in Q2.30 ----------------
  logic                          sq2_vld;
  logic [dtq_pkg::SIDE_W-1:0]    sq2_side;
  logic [dtq_pkg::SQ_OUT_W-1:0]  root_s;
  sq2_side_t                     sd8;

  dtq_sqrt_pipe u_sqrt_trace (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vm4_r),
    .in_side  (dtq_pkg::SIDE_W'(sd4_r)),
    .in_rad   (rad4_r),
    .out_vld  (sq2_vld),
    .out_side (sq2_side),
    .out_root (root_s)
  );

  assign sd8 = sq2_side[$bits(sq2_side_t)-1:0];

  // ---------------- S8: w and vector numerators ----------------
  logic                          v8_r;
  logic [dtq_pkg::DV_NUM_W-1:0]  num8_r [3];
  logic [dtq_pkg::DV_DEN_W-1:0]  s8_r;
  dv2_side_t                     sd8_r;
  logic [32:0]                   whalf;

  assign whalf = (33'(root_s) + 33'd1) >> 1;

  always_ff @(posedge clk) begin
    if (en) begin
      num8_r[0] <= dtq_pkg::DV_NUM_W'({sd8.amx, 29'b0}) + dtq_pkg::DV_NUM_W'(root_s >> 1);
      num8_r[1] <= dtq_pkg::DV_NUM_W'({sd8.amy, 29'b0}) + dtq_pkg::DV_NUM_W'(root_s >> 1);
      num8_r[2] <= dtq_pkg::DV_NUM_W'({sd8.amz, 29'b0}) + dtq_pkg::DV_NUM_W'(root_s >> 1);
      s8_r         <= root_s;
      sd8_r.status <= sd8.status;
      sd8_r.asg    <= sd8.asg;
      sd8_r.w      <= (whalf > 33'(dtq_pkg::ONE_Q30)) ? dtq_pkg::ONE_Q30 : whalf[30:0];
    end
  end

  // ---------------- vector part divisions ----------------
  logic                        dv2_vld;
  logic [dtq_pkg::SIDE_W-1:0]  dv2_side;
  logic [dtq_pkg::DV_Q_W-1:0]  quo2 [3];
  logic                        ovf2 [3];
  dv2_side_t                   sd9;

  for (genvar j = 0; j < 3; j++) begin : g_dv2
    if (j == 0) begin : g_main
      dtq_div_pipe u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v8_r),
        .in_side  (dtq_pkg::SIDE_W'(sd8_r)),
        .in_num   (num8_r[j]),
        .in_den   (s8_r),
        .out_vld  (dv2_vld),
        .out_side (dv2_side),
        .out_quo  (quo2[j]),
        .out_ovf  (ovf2[j])
      );
    end else begin : g_aux
      dtq_div_pipe u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (v8_r),
        .in_side  ('0),
        .in_num   (num8_r[j]),
        .in_den   (s8_r),
        .out_vld  (),
        .out_side (),
        .out_quo  (quo2[j]),
        .out_ovf  (ovf2[j])
      );
    end
  end

  assign sd9 = dv2_side[$bits(dv2_side_t)-1:0];

  // ---------------- output register: saturate, sign, zero on error -----------
  logic               out_vld_r;
  logic signed [31:0] qw_r, qx_r, qy_r, qz_r;
  logic [1:0]         st_r;
  logic [30:0]        qmag [3];
  logic signed [31:0] qval [3];
  logic               err;

  assign err = sd9.status != dtq_pkg::ST_OK;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qmag[i] = (ovf2[i] || quo2[i] > 32'(dtq_pkg::ONE_Q30)) ? dtq_pkg::ONE_Q30
                                                              : quo2[i][30:0];
      qval[i] = sd9.asg[i] ? -$signed(32'(qmag[i])) : $signed(32'(qmag[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qw_r <= err ? '0 : $signed(32'(sd9.w));
      qx_r <= err ? '0 : qval[0];
      qy_r <= err ? '0 : qval[1];
      qz_r <= err ? '0 : qval[2];
      st_r <= sd9.status;
    end
  end

  // ---------------- valid chain of the local stages ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r      <= 1'b0;
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      v5_r      <= 1'b0;
      v6_r      <= 1'b0;
      v7_r      <= 1'b0;
      vm1_r     <= 1'b0;
      vm2_r     <= 1'b0;
      vm3_r     <= 1'b0;
      vm4_r     <= 1'b0;
      v8_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      v0_r      <= in_tvalid;
      v1_r      <= v0_r;
      v2_r      <= v1_r;
      v3_r      <= v2_r;
      v4_r      <= v3_r;
      v5_r      <= v4_r;
      v6_r      <= sq1_vld;
      v7_r      <= dv1_vld;
      vm1_r     <= v7_r;
      vm2_r     <= vm1_r;
      vm3_r     <= vm2_r;
      vm4_r     <= vm3_r;
      v8_r      <= sq2_vld;
      out_vld_r <= dv2_vld;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {qz_r, qy_r, qx_r, qw_r};
  assign out_tuser  = st_r;

  // ---------------- assertions ----------------
  `DTQ_ASSERT(a_err_zeroes, !(out_vld_r && st_r != dtq_pkg::ST_OK) || (qw_r == 0 && qx_r == 0 && qy_r == 0 && qz_r == 0))
  `DTQ_ASSERT(a_ok_w_pos, !(out_vld_r && st_r == dtq_pkg::ST_OK) || qw_r > 0)
  `DTQ_ASSERT(a_vec_range, !out_vld_r || ((qx_r <= 32'sh4000_0000) && (qx_r >= -32'sh4000_0000) && (qy_r <= 32'sh4000_0000) && (qy_r >= -32'sh4000_0000) && (qz_r <= 32'sh4000_0000) && (qz_r >= -32'sh4000_0000)))
  `DTQ_ASSERT_NEXT(a_stall_freeze, !en, $stable(v0_r) && $stable(v5_r) && $stable(vm4_r))

endmodule

/* tb/direction_to_quaternion_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// direction_to_quaternion_check
// Watches both streams of the look-rotation block, works out the expected
// quaternion and status for every accepted input transaction, and compares
// each output transaction with the oldest one outstanding.
// ----------------------------------------------------------------------------
module direction_to_quaternion_check (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [191:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  input  logic [1:0]   out_tuser,
  output int           fail_count,
  output int           in_taken,
  output int           quats_due,
  output int           ok_seen,
  output int           special_seen
);

  localparam longint ONE = 64'sd1 << 30;

  typedef struct packed {
    logic [31:0] w;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  status;
  } quat_t;

  quat_t quat_fifo[$];

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  // half away from zero
  function automatic longint div_near(longint num, longint unsigned den);
    longint unsigned q;
    q = (mag(num) + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint shr30_near(longint v);
    longint unsigned q;
    q = (mag(v) + (64'd1 << 29)) >> 30;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp_q30(longint v);
    if (v > ONE) return ONE;
    if (v < -ONE) return -ONE;
    return v;
  endfunction

  function automatic quat_t look_rotation(logic [191:0] pts);
    quat_t q;
    longint dv[3];
    longint unsigned m[3];
    longint unsigned mx, len, hl, s;
    longint sd[3];
    longint fx, fy, fz, rx, rz, ux, uy, uz, t;
    q = '0;
    for (int i = 0; i < 3; i++) begin
      dv[i] = longint'($signed(pts[96 + 32*i +: 32])) - longint'($signed(pts[32*i +: 32]));
      m[i] = mag(dv[i]);
    end
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    if (mx == 0) begin
      q.status = dtq_pkg::ST_ZERO;
      return q;
    end
    // common power-of-two scale into [2^29, 2^30)
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      mx <<= 1;
    end
    for (int i = 0; i < 3; i++) sd[i] = (dv[i] < 0) ? -longint'(m[i]) : longint'(m[i]);
    if (sd[0] == 0 && sd[2] == 0) begin
      q.status = dtq_pkg::ST_VERT;
      return q;
    end
    len = root_floor(m[0]*m[0] + m[1]*m[1] + m[2]*m[2]);
    fx = div_near(sd[0] * ONE, len);
    fy = div_near(sd[1] * ONE, len);
    fz = div_near(sd[2] * ONE, len);
    hl = root_floor(m[0]*m[0] + m[2]*m[2]);
    rx = div_near(sd[2] * ONE, hl);
    rz = div_near(-sd[0] * ONE, hl);
    ux = shr30_near(fy * rz);
    uy = shr30_near(fz * rx - fx * rz);
    uz = shr30_near(-(fy * rx));
    t = ONE + rx + uy + fz;
    if (t <= 0) begin
      q.status = dtq_pkg::ST_TRACE;
      return q;
    end
    s = root_floor(longint'(t) << 30);
    q.w = 32'(clamp_q30(longint'((s + 1) >> 1)));
    q.x = 32'(clamp_q30(div_near((uz - fy) * (64'sd1 << 29), s)));
    q.y = 32'(clamp_q30(div_near((fx - rz) * (64'sd1 << 29), s)));
    q.z = 32'(clamp_q30(div_near(-ux * (64'sd1 << 29), s)));
    q.status = dtq_pkg::ST_OK;
    return q;
  endfunction

  always @(posedge clk) begin
    quat_t exp_q;
    if (!rst_n) begin
      fail_count   <= 0;
      in_taken     <= 0;
      quats_due    <= 0;
      ok_seen      <= 0;
      special_seen <= 0;
      quat_fifo.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        quat_fifo.push_back(look_rotation(in_tdata));
        in_taken <= in_taken + 1;
      end
      if (out_tvalid && out_tready) begin
        if (quat_fifo.size() == 0) begin
          $error("unexpected output transaction: tdata=%h tuser=%0d", out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          exp_q = quat_fifo.pop_front();
          if (exp_q.status == dtq_pkg::ST_OK) ok_seen <= ok_seen + 1;
          else special_seen <= special_seen + 1;
          if (out_tdata[31:0] !== exp_q.w)
            $error("quat_w: expected %h, got %h", exp_q.w, out_tdata[31:0]);
          if (out_tdata[63:32] !== exp_q.x)
            $error("quat_x: expected %h, got %h", exp_q.x, out_tdata[63:32]);
          if (out_tdata[95:64] !== exp_q.y)
            $error("quat_y: expected %h, got %h", exp_q.y, out_tdata[95:64]);
          if (out_tdata[127:96] !== exp_q.z)
            $error("quat_z: expected %h, got %h", exp_q.z, out_tdata[127:96]);
          if (out_tuser !== exp_q.status)
            $error("status: expected %0d, got %0d", exp_q.status, out_tuser);
          if ({out_tdata, out_tuser} !== {exp_q.z, exp_q.y, exp_q.x, exp_q.w, exp_q.status})
            fail_count <= fail_count + 1;
        end
      end
      quats_due <= quat_fifo.size();
    end
  end

endmodule

/* tb/direction_to_quaternion_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// direction_to_quaternion_test
// Drives point pairs into the look-rotation block with random gaps and output
// back-pressure; a separate checker predicts and compares every quaternion.
// ----------------------------------------------------------------------------
module direction_to_quaternion_test;

  localparam int RAND_POINTS = 800;
  localparam int DRAIN_WAIT  = 200;   // idle wait after the pipe has drained

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [191:0] in_tdata = '0;    // from_x, from_y, from_z, to_x, to_y, to_z (low up)
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;        // quat_w, quat_x, quat_y, quat_z (low up)
  logic [1:0]   out_tuser;        // status

  int  fail_count, in_taken, quats_due, ok_seen, special_seen;
  bit  calm = 1'b0;               // no idling on either side in the tail

  always #4 clk = ~clk;

  direction_to_quaternion dut (.*);

  direction_to_quaternion_check checker_i (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .fail_count, .in_taken, .quats_due, .ok_seen, .special_seen
  );

  // receiver: random stall bursts on out_tready
  always @(negedge clk) begin
    if (!calm && $urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 8) - 1) @(negedge clk);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // one transaction; returns at the falling edge after it was taken
  task automatic send_points(logic [31:0] fx, fy, fz, tx, ty, tz);
    int taken_before;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    taken_before = in_taken;
    in_tvalid <= 1'b1;
    in_tdata  <= {tz, ty, tx, fz, fy, fx};
    do @(negedge clk); while (in_taken == taken_before);
  endtask

  task automatic send_delta(logic [31:0] dx, dy, dz);
    logic [31:0] bx, by, bz;
    bx = $urandom;
    by = $urandom;
    bz = $urandom;
    send_points(bx, by, bz, bx + dx, by + dy, bz + dz);
  endtask

  function automatic logic [31:0] rand_small();
    logic [31:0] v;
    v = $urandom_range(1, 1 << $urandom_range(0, 20));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  initial begin
    logic [31:0] a;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes, the degenerate cases, the large-component region
    send_points(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_points(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_points(32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 0);
    send_points(0, 0, 32'h7fff_ffff, 0, 0, 32'h8000_0000);
    send_points(32'h1234_5678, 32'hdead_beef, 32'h0, 32'h1234_5678, 32'hdead_beef, 32'h0);
    send_points(0, 0, 0, 0, 0, 0);
    send_points(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_points(5, 0, 9, 5, 1, 9);                       // straight up
    send_points(5, 32'h7fff_ffff, 9, 5, 32'h8000_0000, 9); // straight down
    send_points(0, 0, 0, 0, 0, 32'hffff_0000);           // along -z, trace zero
    send_points(0, 0, 0, 0, 0, 32'h8000_0000);
    send_points(0, 0, 0, 1, 0, 32'h8000_0000);           // near -z, big components
    send_points(0, 0, 0, 32'hffff_ffff, 0, 32'h8000_0000);
    send_points(0, 0, 0, 1, 0, 32'hffff_ffff);           // tiny, shifted up hard
    send_points(0, 0, 0, 0, 0, 1);
    send_points(0, 0, 0, 1, 1, 1);
    send_points(0, 0, 0, 32'hffff_ffff, 32'h7fff_ffff, 1);
    send_points(0, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'hfffd_0000);
    send_points(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa);

    // hold the sender until the pipe has drained
    in_tvalid <= 1'b0;
    while (quats_due != 0 || in_taken != ok_seen + special_seen) @(negedge clk);

    for (int n = 0; n < RAND_POINTS; n++) begin
      if (n == RAND_POINTS - 100) calm = 1'b1;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7:
          send_points($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        8, 9, 10, 11:
          send_delta(rand_small(), rand_small(), rand_small());
        12, 13, 14: begin
          // close to -z: trace near zero, x/y/z may saturate
          a = $urandom_range(1, 1 << 20);
          send_delta($urandom_range(0, 1) ? rand_small() : 0, rand_small(), -a * 1024);
        end
        15: begin
          a = $urandom;
          send_points(a, a ^ 32'hffff, $urandom, a, a ^ 32'hffff, $urandom);
        end
        16: send_delta(0, 0, 0);
        17: send_delta(0, rand_small(), 0);
        default:
          send_delta($urandom_range(0, 2) - 1, $urandom_range(0, 2) - 1,
                     $urandom_range(0, 2) - 1);
      endcase
    end
    in_tvalid <= 1'b0;

    while (quats_due != 0 || in_taken != ok_seen + special_seen) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("covered %0d point pairs: %0d regular quaternions, %0d degenerate results",
             in_taken, ok_seen, special_seen);
    if (fail_count == 0 && quats_due == 0)
      $display("direction_to_quaternion_test passed");
    else
      $display("direction_to_quaternion_test failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("direction_to_quaternion_test failed");
    $finish;
  end

endmodule
